// File: design/lcc_pkg.sv
package lcc_pkg;

  localparam int KEY_W       = 48;
  localparam int HANDLE_IO_W = 16;
  localparam int SLOT_IO_W   = 4;
  localparam int CAP_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [9:0] STATUS_OK        = 10'd200;
  localparam logic [9:0] STATUS_NOT_FOUND = 10'd404;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLOSE   = 2'd2
  } cmd_e;

  localparam logic [2:0] OUT_MISS     = 3'd0;
  localparam logic [2:0] OUT_REUSED   = 3'd1;
  localparam logic [2:0] OUT_STORED   = 3'd2;
  localparam logic [2:0] OUT_EVICTED  = 3'd3;
  localparam logic [2:0] OUT_NOT_ELIG = 3'd4;
  localparam logic [2:0] OUT_FREED    = 3'd5;

endpackage

// File: design/lcc_cell.sv
module lcc_cell import lcc_pkg::*; #(
  parameter int  INDEX       = 0,
  parameter int  SLOT_W      = 4,
  parameter int  HANDLE_BITS = 16,
  parameter int  CNT_W       = 5,
  parameter type job_t       = logic,
  parameter type scan_t      = logic,
  parameter type upd_t       = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  job_t  job,
  input  upd_t  upd,
  input  scan_t scan_in,
  output scan_t scan_out
);

  localparam logic [SLOT_W-1:0] SELF     = SLOT_W'(INDEX);
  localparam logic [CNT_W-1:0]  SELF_CNT = CNT_W'(INDEX);

  logic                   valid;
  logic [SLOT_W-1:0]      age;
  logic [KEY_W-1:0]       key;
  logic [HANDLE_BITS-1:0] handle;

  logic                   valid_next;
  logic [SLOT_W-1:0]      age_next;
  logic                   in_cap;
  logic                   dropped;
  logic                   valid_kept;
  logic [SLOT_W-1:0]      age_kept;
  logic                   put_here;
  scan_t                  scan_next;

  assign in_cap = SELF_CNT < job.cap_used;

  always_comb begin
    scan_next = scan_in;
    case (job.cmd)
      CMD_GET: begin
        if (valid && (job.single || key == job.key) &&
            (!scan_in.hit || age < scan_in.hit_age)) begin
          scan_next.hit        = 1'b1;
          scan_next.hit_slot   = SELF;
          scan_next.hit_age    = age;
          scan_next.hit_handle = handle;
        end
      end
      CMD_RELEASE: begin
        if (in_cap) begin
          if (!valid && !scan_in.free_found) begin
            scan_next.free_found = 1'b1;
            scan_next.free_slot  = SELF;
          end
          if (!scan_in.ev_found || age > scan_in.ev_age) begin
            scan_next.ev_found  = 1'b1;
            scan_next.ev_slot   = SELF;
            scan_next.ev_age    = age;
            scan_next.ev_handle = handle;
          end
        end
      end
      CMD_CLOSE: begin
        if (valid && int'(job.close_slot) == INDEX) begin
          scan_next.hit        = 1'b1;
          scan_next.hit_slot   = SELF;
          scan_next.hit_age    = age;
          scan_next.hit_handle = handle;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

  // drop first, then put as most recent
  always_comb begin
    dropped    = upd.drop && upd.drop_slot == SELF;
    put_here   = upd.put && upd.put_slot == SELF;
    valid_kept = valid && !dropped;
    if (dropped) begin
      age_kept = '0;
    end else if (valid && upd.drop && age > upd.drop_age) begin
      age_kept = age - 1'b1;
    end else begin
      age_kept = age;
    end
    valid_next = valid_kept;
    age_next   = age_kept;
    if (upd.put) begin
      if (put_here) begin
        valid_next = 1'b1;
        age_next   = '0;
      end else if (valid_kept) begin
        age_next = age_kept + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (upd.en) begin
      valid <= valid_next;
      age   <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && put_here) begin
      key    <= upd.key;
      handle <= upd.handle;
    end
  end

endmodule

// File: design/lru_connection_cache.sv
// A search token walks the cell chain one cell per cycle; s_tready is high only
// in ST_IDLE, so no new input is taken until the result is captured and, once
// the output is free, loaded while all cells update.
// A new input is taken while the previous result still waits on m_tready.
// Reset (rst, synchronous): pool empty, all ages zero, capacity 16,
// single_mode 0; keys and handles are written only on store.
module lru_connection_cache import lcc_pkg::*; #(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // peer_key[47:0], conn_handle[63:48], has_conn[64], failed[65],
  // resp_status[75:66], hdr_done[76], body_empty[77], close_slot[81:78]
  input  logic [87:0]          s_tdata,
  // cmd[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // handle_out[15:0], slot_out[19:16]
  output logic [23:0]          m_tdata,
  // outcome[2:0]
  output logic [2:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data
);

  localparam int SLOT_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

  typedef struct packed {
    cmd_e                   cmd;
    logic                   single;
    logic [CNT_W-1:0]       cap_used;
    logic [KEY_W-1:0]       key;
    logic [SLOT_IO_W-1:0]   close_slot;
  } job_t;

  typedef struct packed {
    logic                   tok;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_slot;
    logic [SLOT_W-1:0]      hit_age;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic                   ev_found;
    logic [SLOT_W-1:0]      ev_slot;
    logic [SLOT_W-1:0]      ev_age;
    logic [HANDLE_BITS-1:0] ev_handle;
  } scan_t;

  typedef struct packed {
    logic                   en;
    logic                   drop;
    logic [SLOT_W-1:0]      drop_slot;
    logic [SLOT_W-1:0]      drop_age;
    logic                   put;
    logic [SLOT_W-1:0]      put_slot;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CAP_W-1:0]       capacity;
  logic                   single_mode;
  logic [CNT_W-1:0]       cap_used;
  job_t                   job;
  logic                   job_ok;
  logic [HANDLE_BITS-1:0] job_handle;
  logic                   start;
  scan_t                  scan_head;
  scan_t                  scan_bus [POOL_DEPTH];
  scan_t                  res;
  upd_t                   upd;
  logic                   in_xfer;
  logic                   out_free;
  logic                   in_ok;
  logic [9:0]             in_status;
  logic [2:0]             outcome;
  logic [HANDLE_IO_W-1:0] hout;
  logic [SLOT_IO_W-1:0]   sout;

  assign in_xfer   = s_tvalid && s_tready;
  assign s_tready  = state == ST_IDLE;
  assign out_free  = !m_tvalid || m_tready;
  assign in_status = s_tdata[75:66];
  assign in_ok     = !s_tdata[65] && s_tdata[64] &&
                     (in_status == STATUS_NOT_FOUND ||
                      (in_status == STATUS_OK && s_tdata[76] && s_tdata[77]));
  assign cap_used  = (int'(capacity) > POOL_DEPTH) ? CNT_W'(POOL_DEPTH)
                                                   : CNT_W'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RESET;
      single_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:    capacity    <= cfg_data;
        CFG_SINGLE_MODE: single_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job.cmd        <= cmd_e'(s_tuser);
      job.single     <= single_mode;
      job.cap_used   <= cap_used;
      job.key        <= s_tdata[47:0];
      job.close_slot <= s_tdata[81:78];
      job_ok         <= in_ok;
      job_handle     <= HANDLE_BITS'(s_tdata[63:48]);
    end
  end

  always_comb begin
    scan_head     = '0;
    scan_head.tok = start;
  end

  genvar gi;
  generate
    for (gi = 0; gi < POOL_DEPTH; gi++) begin : g_cell
      lcc_cell #(
        .INDEX       (gi),
        .SLOT_W      (SLOT_W),
        .HANDLE_BITS (HANDLE_BITS),
        .CNT_W       (CNT_W),
        .job_t       (job_t),
        .scan_t      (scan_t),
        .upd_t       (upd_t)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .job      (job),
        .upd      (upd),
        .scan_in  ((gi == 0) ? scan_head : scan_bus[(gi == 0) ? 0 : gi - 1]),
        .scan_out (scan_bus[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_xfer) state_next = ST_SCAN;
      ST_SCAN: if (scan_bus[POOL_DEPTH-1].tok) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_bus[POOL_DEPTH-1].tok) begin
      res <= scan_bus[POOL_DEPTH-1];
    end
  end

  always_comb begin
    outcome    = OUT_MISS;
    hout       = '0;
    sout       = '0;
    upd        = '0;
    upd.en     = state == ST_DONE && out_free;
    upd.key    = job.key;
    upd.handle = job_handle;
    case (job.cmd)
      CMD_GET: begin
        if (res.hit) begin
          outcome       = OUT_REUSED;
          hout          = HANDLE_IO_W'(res.hit_handle);
          sout          = SLOT_IO_W'(res.hit_slot);
          upd.drop      = 1'b1;
          upd.drop_slot = res.hit_slot;
          upd.drop_age  = res.hit_age;
        end
      end
      CMD_RELEASE: begin
        if (!job_ok || job.cap_used == '0) begin
          outcome = OUT_NOT_ELIG;
        end else if (res.free_found) begin
          outcome      = OUT_STORED;
          sout         = SLOT_IO_W'(res.free_slot);
          upd.put      = 1'b1;
          upd.put_slot = res.free_slot;
        end else begin
          outcome       = OUT_EVICTED;
          hout          = HANDLE_IO_W'(res.ev_handle);
          sout          = SLOT_IO_W'(res.ev_slot);
          upd.drop      = 1'b1;
          upd.drop_slot = res.ev_slot;
          upd.drop_age  = res.ev_age;
          upd.put       = 1'b1;
          upd.put_slot  = res.ev_slot;
        end
      end
      CMD_CLOSE: begin
        sout = job.close_slot;
        if (res.hit) begin
          outcome       = OUT_FREED;
          hout          = HANDLE_IO_W'(res.hit_handle);
          upd.drop      = 1'b1;
          upd.drop_slot = res.hit_slot;
          upd.drop_age  = res.hit_age;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd.en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      m_tdata <= {4'b0, sout, hout};
      m_tuser <= outcome;
    end
  end

  a_tok_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_bus[POOL_DEPTH-1].tok |-> state == ST_SCAN)
    else $error("search token left the chain outside of a scan");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SCAN && start)
    else $error("input transfer did not start a scan");

  a_evict_same_slot: assert property (@(posedge clk) disable iff (rst)
    upd.en && upd.drop && upd.put |-> upd.put_slot == upd.drop_slot)
    else $error("eviction stores into a slot other than the evicted one");

  a_update_loads_result: assert property (@(posedge clk) disable iff (rst)
    upd.en |=> m_tvalid && state == ST_IDLE)
    else $error("pool update without a result loaded");

endmodule
